// ----- hw/rtl/ir_pulse_width_capture_macros.svh -----
// Assertion macros used by the IR pulse width capture RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef IR_PULSE_WIDTH_CAPTURE_MACROS_SVH
`define IR_PULSE_WIDTH_CAPTURE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define IRPWC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define IRPWC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/irpwc_pkg.sv -----
// Types and constants for the IR pulse width capture block.
// No dependencies.
package irpwc_pkg;

    localparam int TICK_W      = 16;
    localparam int USEC_W      = 8;
    localparam int DUR_W       = 16;
    localparam int PROD_W      = TICK_W + USEC_W;
    localparam int INDEX_W     = 6;
    localparam int COUNT_OUT_W = 7;
    localparam int OP_W        = 3;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [TICK_W-1:0] TICK_MAX   = '1;
    localparam logic [TICK_W-1:0] GAP_RESET  = 16'd100;
    localparam logic [USEC_W-1:0] USEC_RESET = 8'd50;
    localparam logic [PROD_W-1:0] MARK_MAX   = 24'd32767;
    localparam logic [PROD_W-1:0] SPACE_MAX  = 24'd32768;

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 3'd0,
        OP_READ    = 3'd1,
        OP_ACK     = 3'd2,
        OP_RELEASE = 3'd3,
        OP_START   = 3'd4,
        OP_STOP    = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_MARK  = 2'd1,
        PH_SPACE = 2'd2,
        PH_DONE  = 2'd3
    } phase_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GAP_TICKS     = 1'b0,
        REG_USEC_PER_TICK = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic               ir_mark;
        logic [INDEX_W-1:0] read_index;
    } in_item_t;

    typedef struct packed {
        logic                    irq;
        logic                    frame_ready;
        logic [COUNT_OUT_W-1:0]  entry_count;
        logic signed [DUR_W-1:0] read_value;
        logic [1:0]              phase;
    } out_item_t;

endpackage

// ----- hw/rtl/irpwc_item_if.sv -----
// Input transaction channel: valid/ready plus one operation item.
// Depends on irpwc_pkg.
interface irpwc_item_if;
    logic                 valid;
    logic                 ready;
    irpwc_pkg::in_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/irpwc_result_if.sv -----
// Result transaction channel: valid/ready plus one status/read item.
// Depends on irpwc_pkg.
interface irpwc_result_if;
    logic                 valid;
    logic                 ready;
    irpwc_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/irpwc_cfg_if.sv -----
// Configuration write channel: valid/ready, register index and write data.
// Depends on irpwc_pkg.
interface irpwc_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [irpwc_pkg::CFG_INDEX_W-1:0]   index;
    logic [irpwc_pkg::CFG_DATA_W-1:0]    wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ----- hw/rtl/irpwc_ram.sv -----
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
module irpwc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/ir_pulse_width_capture.sv -----
// Top level of the IR pulse width capture block.
// Depends on irpwc_pkg, the three channel interfaces, irpwc_ram and the macros header.
`include "ir_pulse_width_capture_macros.svh"

// Samples an IR detector on each tick transaction and records one frame as signed
// durations in microseconds (positive for mark, negative for space) in a
// BUFFER_DEPTH-entry RAM. Host transactions read an entry, acknowledge the
// interrupt, release the frame, or start/stop reception; any host transaction
// aborts a frame in progress. Every input transaction produces exactly one result
// transaction, valid on the cycle after acceptance, carrying the updated status
// and, for a read, the stored entry (0 beyond the count). One transaction is
// taken per clock: the whole update is a single cycle of logic into the state
// registers, with the entry read through the RAM's registered read port. Input
// is stalled only while a result waits and result_out is not ready. There is no
// clearing pass after reset. Configuration writes are accepted every cycle and
// must be issued only while the block is idle.
module ir_pulse_width_capture #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    irpwc_item_if.sink        item_in,
    irpwc_result_if.source    result_out,
    irpwc_cfg_if.sink         cfg
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int IW = (CW > irpwc_pkg::INDEX_W) ? CW : irpwc_pkg::INDEX_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);

    irpwc_pkg::phase_t                 phase_reg, phase_next;
    logic [irpwc_pkg::TICK_W-1:0]      tick_reg, tick_next;
    logic [CW-1:0]                     count_reg, count_next;
    logic                              enabled_reg, enabled_next;
    logic                              irq_reg, irq_next;
    logic                              rd_hit_reg, rd_hit_next;
    logic                              out_valid_reg, out_valid_next;
    logic [irpwc_pkg::TICK_W-1:0]      gap_reg, gap_next;
    logic [irpwc_pkg::USEC_W-1:0]      usec_reg, usec_next;

    irpwc_pkg::phase_t                 ph_work;
    logic [CW-1:0]                     cnt_work;
    logic                              accept;
    logic [irpwc_pkg::TICK_W-1:0]      tick_inc;
    logic [irpwc_pkg::PROD_W-1:0]      product;
    logic [irpwc_pkg::PROD_W-1:0]      space_mag;
    logic [irpwc_pkg::DUR_W-1:0]       mark_dur;
    logic [irpwc_pkg::DUR_W-1:0]       space_dur;

    logic                              ram_we;
    logic [irpwc_pkg::DUR_W-1:0]       ram_wdata;
    logic                              ram_re;
    logic [AW-1:0]                     ram_raddr;
    logic [irpwc_pkg::DUR_W-1:0]       ram_rdata;

    assign accept   = item_in.valid && item_in.ready;
    assign tick_inc = (tick_reg == irpwc_pkg::TICK_MAX) ? tick_reg
                                                         : tick_reg + 16'd1;
    assign product  = irpwc_pkg::PROD_W'(tick_inc) * irpwc_pkg::PROD_W'(usec_reg);
    assign mark_dur = (product > irpwc_pkg::MARK_MAX) ? irpwc_pkg::DUR_W'(irpwc_pkg::MARK_MAX)
                                                      : product[irpwc_pkg::DUR_W-1:0];
    assign space_mag = (product > irpwc_pkg::SPACE_MAX) ? irpwc_pkg::SPACE_MAX : product;
    assign space_dur = irpwc_pkg::DUR_W'(irpwc_pkg::PROD_W'(0) - space_mag);

    assign ram_re    = accept && (item_in.data.operation == irpwc_pkg::OP_READ);
    assign ram_raddr = AW'(item_in.data.read_index);

    irpwc_ram #(
        .WIDTH (irpwc_pkg::DUR_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        count_next   = count_reg;
        enabled_next = enabled_reg;
        irq_next     = irq_reg;
        rd_hit_next  = rd_hit_reg;
        ph_work      = phase_reg;
        cnt_work     = count_reg;
        ram_we       = 1'b0;
        ram_wdata    = mark_dur;

        if (accept)
        begin
            rd_hit_next = 1'b0;
            if (item_in.data.operation == irpwc_pkg::OP_TICK)
            begin
                if (enabled_reg)
                begin
                    tick_next = tick_inc;
                    if (ph_work != irpwc_pkg::PH_DONE && count_reg >= DEPTH_C)
                    begin
                        ph_work  = irpwc_pkg::PH_DONE;
                        irq_next = 1'b1;
                    end
                    case (ph_work)
                        irpwc_pkg::PH_IDLE:
                        begin
                            if (item_in.data.ir_mark)
                            begin
                                if (tick_inc >= gap_reg)
                                begin
                                    cnt_work = '0;
                                    ph_work  = irpwc_pkg::PH_MARK;
                                end
                                tick_next = '0;
                            end
                        end
                        irpwc_pkg::PH_MARK:
                        begin
                            if (!item_in.data.ir_mark)
                            begin
                                ram_wdata = mark_dur;
                                if (count_reg < DEPTH_C)
                                begin
                                    ram_we   = 1'b1;
                                    cnt_work = count_reg + CW'(1);
                                end
                                tick_next = '0;
                                ph_work   = irpwc_pkg::PH_SPACE;
                            end
                        end
                        irpwc_pkg::PH_SPACE:
                        begin
                            if (item_in.data.ir_mark)
                            begin
                                ram_wdata = space_dur;
                                if (count_reg < DEPTH_C)
                                begin
                                    ram_we   = 1'b1;
                                    cnt_work = count_reg + CW'(1);
                                end
                                tick_next = '0;
                                ph_work   = irpwc_pkg::PH_MARK;
                            end
                            else if (tick_inc > gap_reg)
                            begin
                                ph_work  = irpwc_pkg::PH_DONE;
                                irq_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (item_in.data.ir_mark)
                            begin
                                tick_next = '0;
                            end
                        end
                    endcase
                end
            end
            else
            begin
                // host transaction aborts a frame in progress
                if (ph_work == irpwc_pkg::PH_MARK || ph_work == irpwc_pkg::PH_SPACE)
                begin
                    cnt_work = '0;
                    ph_work  = irpwc_pkg::PH_IDLE;
                end
                case (item_in.data.operation)
                    irpwc_pkg::OP_READ:
                    begin
                        rd_hit_next = IW'(item_in.data.read_index) < IW'(cnt_work);
                    end
                    irpwc_pkg::OP_ACK:
                    begin
                        if (ph_work == irpwc_pkg::PH_DONE)
                        begin
                            irq_next = 1'b0;
                        end
                    end
                    irpwc_pkg::OP_RELEASE:
                    begin
                        if (ph_work == irpwc_pkg::PH_DONE)
                        begin
                            cnt_work = '0;
                            ph_work  = irpwc_pkg::PH_IDLE;
                        end
                    end
                    irpwc_pkg::OP_START:
                    begin
                        irq_next     = 1'b0;
                        cnt_work     = '0;
                        ph_work      = irpwc_pkg::PH_IDLE;
                        enabled_next = 1'b1;
                    end
                    irpwc_pkg::OP_STOP:
                    begin
                        enabled_next = 1'b0;
                        irq_next     = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            phase_next = ph_work;
            count_next = cnt_work;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        gap_next  = gap_reg;
        usec_next = usec_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                irpwc_pkg::REG_GAP_TICKS:     gap_next  = cfg.wdata;
                irpwc_pkg::REG_USEC_PER_TICK: usec_next = cfg.wdata[irpwc_pkg::USEC_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= irpwc_pkg::PH_IDLE;
            tick_reg      <= '0;
            count_reg     <= '0;
            enabled_reg   <= 1'b0;
            irq_reg       <= 1'b0;
            rd_hit_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            gap_reg       <= irpwc_pkg::GAP_RESET;
            usec_reg      <= irpwc_pkg::USEC_RESET;
        end
        else
        begin
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            count_reg     <= count_next;
            enabled_reg   <= enabled_next;
            irq_reg       <= irq_next;
            rd_hit_reg    <= rd_hit_next;
            out_valid_reg <= out_valid_next;
            gap_reg       <= gap_next;
            usec_reg      <= usec_next;
        end
    end

    // outputs; state registers hold the status of the pending result
    always_comb
    begin
        item_in.ready                = !out_valid_reg || result_out.ready;
        cfg.ready                    = 1'b1;
        result_out.valid             = out_valid_reg;
        result_out.data.irq          = irq_reg;
        result_out.data.frame_ready  = (phase_reg == irpwc_pkg::PH_DONE);
        result_out.data.entry_count  = irpwc_pkg::COUNT_OUT_W'(count_reg);
        result_out.data.read_value   = rd_hit_reg ? $signed(ram_rdata) : '0;
        result_out.data.phase        = phase_reg;
    end

    `IRPWC_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= DEPTH_C,
        "entry count exceeds buffer depth")
    `IRPWC_ASSERT_SAME(a_write_in_range, ram_we, count_reg < DEPTH_C,
        "store written beyond buffer depth")
    `IRPWC_ASSERT_SAME(a_frame_needs_enable,
        phase_reg == irpwc_pkg::PH_MARK || phase_reg == irpwc_pkg::PH_SPACE,
        enabled_reg, "frame in progress while reception is stopped")
    `IRPWC_ASSERT_NEXT(a_host_aborts,
        accept && item_in.data.operation != irpwc_pkg::OP_TICK,
        phase_reg != irpwc_pkg::PH_MARK && phase_reg != irpwc_pkg::PH_SPACE,
        "host transaction left a frame in progress")
    `IRPWC_ASSERT_SAME(a_irq_rises_on_done, $rose(irq_reg),
        phase_reg == irpwc_pkg::PH_DONE, "interrupt raised without a finished frame")

endmodule
